[design/smuv_pkg.sv]
// Package for splitmix_unit_vector_init: controller states, command/status structs,
// SplitMix64 constants. Used by the datapath, controller and top level; no dependencies.
package smuv_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORE_GEN,
    ST_SQRT,
    ST_CORE_DIV,
    ST_CORE_OUT,
    ST_DET_GEN,
    ST_DET_OUT
  } smuv_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // take identifier, clear sum and counters
    logic gen_start;  // begin hashing the next component
    logic store_core; // write finished core raw to buffer, accumulate square
    logic sqrt_start;
    logic div_start;  // divide the current core entry
    logic core_out;   // place core result in output register
    logic det_out;    // place detail result in output register
    logic idx_clr;
  } smuv_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gen_done;
    logic sqrt_done;
    logic div_done;
  } smuv_sts_t;

endpackage

[design/smuv_datapath.sv]
// Datapath for splitmix_unit_vector_init: hash pipeline, core buffer, sum of squares,
// bit-serial square root and divider, output register. Depends on smuv_pkg.
module smuv_datapath #(
  parameter int CORE_DIM_COUNT = 16,
  parameter int FRAC_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [63:0]           concept_id,
  input  smuv_pkg::smuv_cmd_t   cmd,
  output smuv_pkg::smuv_sts_t   sts,
  input  logic                  out_last,
  output logic signed [17:0]    out_value,
  output logic                  out_detail,
  output logic [5:0]            out_index,
  output logic                  out_last_q
);
  import smuv_pkg::*;

  localparam int RAW_W  = FRAC_BITS + 1;
  localparam int SQ_W   = 2 * FRAC_BITS + 7;   // up to 511 squares of 2^(2F-2)
  localparam int ROOT_W = (SQ_W + 1) / 2;
  localparam int SRC_W  = 2 * ROOT_W;          // radicand padded to whole bit pairs
  localparam int NUM_W  = 2 * FRAC_BITS;       // |raw| << F, |raw| <= 2^(F-1)
  localparam int QW     = NUM_W;
  localparam int VW     = QW + 2;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int SC_W   = $clog2(ROOT_W + 1);
  localparam int CI_W   = (CORE_DIM_COUNT > 1) ? $clog2(CORE_DIM_COUNT) : 1;
  localparam logic signed [VW-1:0] VMAX = VW'(65536);
  localparam logic signed [VW-1:0] VMIN = VW'(-65536);

  logic gen_done, sqrt_done, div_done;
  assign sts = '{gen_done: gen_done, sqrt_done: sqrt_done, div_done: div_done};

  // hash: one 64x64 low product per stage, split in 32-bit halves
  logic [63:0] x;
  logic [2:0]  hs;
  logic [63:0] z;
  logic [63:0] m_lo, m_x1, m_x2;
  logic signed [RAW_W-1:0] raw;
  logic [63:0] mul_a, mul_k;
  logic [1:0]  gen_step;

  assign mul_a = hs[0] ? (z ^ (z >> 30)) : (z ^ (z >> 27));
  assign mul_k = hs[0] ? MIX_MUL_A : MIX_MUL_B;

  always_ff @(posedge clk) begin
    if (rst) begin
      hs <= '0;
      gen_step <= '0;
      gen_done <= 1'b0;
    end else begin
      gen_done <= 1'b0;
      if (cmd.load) x <= concept_id;
      if (cmd.gen_start) begin
        x <= x + GOLDEN_GAMMA;
        z <= x + GOLDEN_GAMMA;
        hs <= 3'd1;
        gen_step <= 2'd0;
      end else if (hs != 3'd0) begin
        // each multiply: step 0 forms partial products, step 1 combines them
        if (gen_step == 2'd0) begin
          m_lo <= {32'd0, mul_a[31:0]} * {32'd0, mul_k[31:0]};
          m_x1 <= {32'd0, mul_a[31:0]} * {32'd0, mul_k[63:32]};
          m_x2 <= {32'd0, mul_a[63:32]} * {32'd0, mul_k[31:0]};
          gen_step <= 2'd1;
        end else begin
          z <= m_lo + {m_x1[31:0] + m_x2[31:0], 32'd0};
          gen_step <= 2'd0;
          if (hs == 3'd2) begin
            hs <= 3'd0;
            gen_done <= 1'b1;
          end else begin
            hs <= 3'd2;
          end
        end
      end
    end
  end

  logic [63:0] zf;
  assign zf  = z ^ (z >> 31);
  assign raw = $signed({1'b0, zf[63 -: FRAC_BITS]}) - $signed(RAW_W'(1) << (FRAC_BITS - 1));

  // core buffer and sum of squares
  logic signed [RAW_W-1:0] core_mem [CORE_DIM_COUNT];
  logic [CI_W-1:0]   wr_idx, rd_idx, rd_idx_next;
  logic [SQ_W-1:0]   sum;
  logic [RAW_W-1:0]  mag;
  logic [2*RAW_W-1:0] mag_sq;
  logic signed [RAW_W-1:0] rd_raw;
  assign mag = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
  assign mag_sq = (2*RAW_W)'(mag) * (2*RAW_W)'(mag);

  // read ahead so the next entry is ready when the next divide starts
  assign rd_idx_next = cmd.idx_clr ? '0 :
                       (cmd.core_out && rd_idx != CI_W'(CORE_DIM_COUNT - 1)) ?
                       rd_idx + 1'b1 : rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.store_core) core_mem[wr_idx] <= raw;
    rd_raw <= core_mem[rd_idx_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum    <= '0;
      wr_idx <= '0;
    end else if (cmd.store_core) begin
      sum    <= sum + SQ_W'(mag_sq);
      wr_idx <= wr_idx + 1'b1;
    end
  end

  // square root, one result bit per cycle
  logic [SQ_W-1:0]   sq_rem;
  logic [ROOT_W-1:0] root;
  logic [SC_W-1:0]   sq_cnt;
  logic [SRC_W-1:0]  sq_src;
  logic [SQ_W+1:0]   rem_sh;
  assign rem_sh = {sq_rem, sq_src[SRC_W-1 -: 2]};
  logic [SQ_W+1:0]   tr2;
  assign tr2 = rem_sh - {{(SQ_W - ROOT_W){1'b0}}, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_src <= SRC_W'(sum);
        sq_rem <= '0;
        root   <= '0;
        sq_cnt <= SC_W'(ROOT_W);
      end else if (sq_cnt != '0) begin
        sq_src <= sq_src << 2;
        if (!tr2[SQ_W+1]) begin
          sq_rem <= tr2[SQ_W-1:0];
          root   <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem <= rem_sh[SQ_W-1:0];
          root   <= {root[ROOT_W-2:0], 1'b0};
        end
        sq_cnt <= sq_cnt - 1'b1;
        if (sq_cnt == SC_W'(1)) sqrt_done <= 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [QW-1:0]     quo;
  logic [ROOT_W:0]   drem;
  logic [CNT_W-1:0]  dv_cnt;
  logic              dv_neg, dv_zero;
  logic signed [RAW_W-1:0] dv_raw;
  logic [ROOT_W+1:0] dsub;
  assign dsub = {drem, quo[QW-1]} - {2'b00, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
      div_done <= 1'b0;
      rd_idx <= '0;
    end else begin
      div_done <= 1'b0;
      rd_idx <= rd_idx_next;
      if (cmd.div_start) begin
        dv_raw  <= rd_raw;
        dv_neg  <= rd_raw[RAW_W-1];
        dv_zero <= (root == '0);
        quo     <= QW'(rd_raw[RAW_W-1] ? RAW_W'(-rd_raw) : RAW_W'(rd_raw)) << FRAC_BITS;
        drem    <= '0;
        dv_cnt  <= CNT_W'(QW);
      end else if (dv_cnt != '0) begin
        if (!dsub[ROOT_W+1]) begin
          drem <= dsub[ROOT_W:0];
          quo  <= {quo[QW-2:0], 1'b1};
        end else begin
          drem <= {drem[ROOT_W-1:0], quo[QW-1]};
          quo  <= {quo[QW-2:0], 1'b0};
        end
        dv_cnt <= dv_cnt - 1'b1;
        if (dv_cnt == CNT_W'(1)) div_done <= 1'b1;
      end
    end
  end

  // output register; both kinds saturate to the field range
  logic signed [VW-1:0] qv, qsel, dsh;
  logic signed [17:0]   cv, dvv;
  assign qv   = dv_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign qsel = dv_zero ? VW'(dv_raw) : qv;
  assign cv   = (qsel > VMAX) ? 18'(VMAX) : (qsel < VMIN) ? 18'(VMIN) : 18'(qsel);
  assign dsh  = VW'(raw >>> 1);
  assign dvv  = (dsh > VMAX) ? 18'(VMAX) : (dsh < VMIN) ? 18'(VMIN) : 18'(dsh);

  logic [5:0] det_idx;
  always_ff @(posedge clk) begin
    if (cmd.load) det_idx <= '0;
    if (cmd.core_out) begin
      out_value  <= cv;
      out_detail <= 1'b0;
      out_index  <= 6'(rd_idx);
      out_last_q <= out_last;
    end else if (cmd.det_out) begin
      out_value  <= dvv;
      out_detail <= 1'b1;
      out_index  <= det_idx;
      out_last_q <= out_last;
      det_idx    <= det_idx + 1'b1;
    end
  end
endmodule

[design/smuv_ctrl.sv]
// Controller for splitmix_unit_vector_init: sequences hashing, root, division and
// output handshake. Depends on smuv_pkg.
module smuv_ctrl #(
  parameter int CORE_DIM_COUNT = 16,
  parameter int DETAIL_COUNT   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  smuv_pkg::smuv_sts_t sts,
  output smuv_pkg::smuv_cmd_t cmd,
  output logic                last_flag
);
  import smuv_pkg::*;

  smuv_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic        ov_next;
  logic        div_busy, div_busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
      div_busy <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= ov_next;
      div_busy <= div_busy_next;
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    ov_next = out_valid && out_stall;
    div_busy_next = div_busy;
    in_stall = 1'b1;
    last_flag = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next = ST_CORE_GEN;
          cnt_next = '0;
        end
      end
      ST_CORE_GEN: begin
        if (!div_busy) begin
          cmd.gen_start = 1'b1;
          div_busy_next = 1'b1;
        end else if (sts.gen_done) begin
          cmd.store_core = 1'b1;
          div_busy_next = 1'b0;
          if (cnt == 6'(CORE_DIM_COUNT - 1)) begin
            state_next = ST_SQRT;
            cnt_next = '0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_SQRT: begin
        if (!div_busy) begin
          cmd.sqrt_start = 1'b1;
          div_busy_next = 1'b1;
        end else if (sts.sqrt_done) begin
          div_busy_next = 1'b0;
          state_next = ST_CORE_DIV;
        end
      end
      ST_CORE_DIV: begin
        if (!div_busy) begin
          cmd.div_start = 1'b1;
          div_busy_next = 1'b1;
        end else if (sts.div_done) begin
          state_next = ST_CORE_OUT;
        end
      end
      ST_CORE_OUT: begin
        if (out_free) begin
          cmd.core_out = 1'b1;
          ov_next = 1'b1;
          div_busy_next = 1'b0;
          last_flag = (DETAIL_COUNT == 0) && (cnt == 6'(CORE_DIM_COUNT - 1));
          if (cnt == 6'(CORE_DIM_COUNT - 1)) begin
            cnt_next = '0;
            state_next = (DETAIL_COUNT == 0) ? ST_IDLE : ST_DET_GEN;
          end else begin
            cnt_next = cnt + 1'b1;
            state_next = ST_CORE_DIV;
          end
        end
      end
      ST_DET_GEN: begin
        if (!div_busy) begin
          cmd.gen_start = 1'b1;
          div_busy_next = 1'b1;
        end else if (sts.gen_done) begin
          state_next = ST_DET_OUT;
        end
      end
      ST_DET_OUT: begin
        if (out_free) begin
          cmd.det_out = 1'b1;
          ov_next = 1'b1;
          div_busy_next = 1'b0;
          last_flag = (cnt == 6'(DETAIL_COUNT - 1));
          if (cnt == 6'(DETAIL_COUNT - 1)) begin
            cnt_next = '0;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
            state_next = ST_DET_GEN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

[design/splitmix_unit_vector_init.sv]
// Top level of splitmix_unit_vector_init: joins controller and datapath.
// Depends on smuv_pkg, smuv_ctrl, smuv_datapath.
//
// Usage
//   Input channel: concept_id with in_valid/in_stall. One identifier is taken
//   at a time; in_stall is low only while the block is idle.
//   Output channel: component_value, is_detail, component_index, last with
//   out_valid/out_stall. CORE_DIM_COUNT core transactions come first (index
//   0 up), then DETAIL_COUNT detail transactions; last marks the final one.
//   Flow: each component is hashed by three 32x32 multipliers used twice,
//   and each core raw is then written to the buffer. The square root of the
//   sum takes one bit a cycle, then each core result needs a bit-serial
//   divide and a hand-off to the output register. Without receiver stalls,
//   most of the time per identifier goes to the serial divider.
//   A stalled output register holds its transaction; the next result waits
//   in the datapath until the register frees.
//   Reset (rst, synchronous) returns the controller to idle and drops
//   out_valid; no memory clearing is needed.
module splitmix_unit_vector_init #(
  parameter int CORE_DIM_COUNT = 16,
  parameter int DETAIL_COUNT   = 16,
  parameter int FRAC_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        concept_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] component_value,
  output logic               is_detail,
  output logic [5:0]         component_index,
  output logic               last
);
  import smuv_pkg::*;

  smuv_cmd_t cmd;
  smuv_sts_t sts;
  logic      last_flag;

  smuv_ctrl #(
    .CORE_DIM_COUNT(CORE_DIM_COUNT),
    .DETAIL_COUNT(DETAIL_COUNT)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd), .last_flag(last_flag)
  );

  smuv_datapath #(
    .CORE_DIM_COUNT(CORE_DIM_COUNT),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .concept_id(concept_id),
    .cmd(cmd), .sts(sts),
    .out_last(last_flag),
    .out_value(component_value),
    .out_detail(is_detail),
    .out_index(component_index),
    .out_last_q(last)
  );
endmodule

[design/smuv_checker.sv]
// Port-level checker for splitmix_unit_vector_init, bound to the top level.
// Depends on nothing but the top level's ports.
module smuv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [17:0] component_value,
  input logic               is_detail,
  input logic [5:0]         component_index,
  input logic               last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(component_value))
    else $error("stalled output changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (component_value <= 18'sd65536 && component_value >= -18'sd65536))
    else $error("value out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second identifier taken while busy");

  a_core_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && is_detail && !last |=> !(out_valid && !is_detail))
    else $error("core after detail");
endmodule

bind splitmix_unit_vector_init smuv_checker u_chk (.*);

[sim/splitmix_unit_vector_init_tb.sv]
// Self-checking testbench for splitmix_unit_vector_init: drives concept identifiers,
// predicts the unit-vector components in SystemVerilog, and checks every output transaction.
// Depends on smuv_pkg and the splitmix_unit_vector_init RTL.
module splitmix_unit_vector_init_tb;
  import smuv_pkg::*;

  localparam int CORES = 16;
  localparam int DETAILS = 16;
  localparam int FRAC = 16;
  localparam int N_RANDOM = 310;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [17:0] value;
    logic               detail;
    logic [5:0]         index;
    logic               last;
  } component_t;

  // directed identifiers; zero, all ones, values next to the wrap point and alternating bit patterns
  localparam int N_DIRECTED = 8;
  logic [63:0] directed_ids [N_DIRECTED] = '{
    64'h0, 64'hffff_ffff_ffff_ffff, 64'h1, 64'h8000_0000_0000_0000,
    64'h7fff_ffff_ffff_ffff, 64'h61c8_8646_80b5_83eb, 64'haaaa_aaaa_aaaa_aaaa,
    64'h5555_5555_5555_5555
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] concept_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] component_value;
  logic is_detail;
  logic [5:0] component_index;
  logic last;

  component_t expected_components [$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  stim_done = 1'b0;
  bit  quiet_phase = 1'b0;
  bit  long_holdoff = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  splitmix_unit_vector_init dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .concept_id(concept_id), .out_valid(out_valid), .out_stall(out_stall),
    .component_value(component_value), .is_detail(is_detail),
    .component_index(component_index), .last(last)
  );

  function automatic logic [63:0] mix64(logic [63:0] z);
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [17:0] clamp18(longint v);
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v[17:0];
  endfunction

  // push the full vector for one identifier onto the expectation queue
  task automatic predict_vector(logic [63:0] id);
    longint      raw [CORES];
    logic [63:0] ctr;
    logic [63:0] sum;
    logic [63:0] norm;
    logic [63:0] mag;
    logic [63:0] quot;
    longint      r;
    longint      v;
    component_t  c;
    ctr = id;
    sum = '0;
    for (int i = 0; i < CORES; i++) begin
      ctr = ctr + GOLDEN_GAMMA;
      raw[i] = longint'(mix64(ctr) >> (64 - FRAC)) - (longint'(1) << (FRAC - 1));
      mag = raw[i] < 0 ? -raw[i] : raw[i];
      sum = sum + mag * mag;
    end
    norm = int_sqrt(sum);
    for (int i = 0; i < CORES; i++) begin
      if (norm == 0) begin
        v = raw[i];
      end else begin
        mag = raw[i] < 0 ? -raw[i] : raw[i];
        quot = (mag << FRAC) / norm;
        v = raw[i] < 0 ? -longint'(quot) : longint'(quot);
      end
      c.value = clamp18(v);
      c.detail = 1'b0;
      c.index = i[5:0];
      c.last = (DETAILS == 0 && i == CORES - 1);
      expected_components.push_back(c);
    end
    for (int i = 0; i < DETAILS; i++) begin
      ctr = ctr + GOLDEN_GAMMA;
      r = longint'(mix64(ctr) >> (64 - FRAC)) - (longint'(1) << (FRAC - 1));
      c.value = clamp18(r >>> 1);
      c.detail = 1'b1;
      c.index = i[5:0];
      c.last = (i == DETAILS - 1);
      expected_components.push_back(c);
    end
  endtask

  // one input transaction, held until accepted
  task automatic send_id(logic [63:0] id);
    predict_vector(id);
    concept_id <= id;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_components.size() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    logic [63:0] id;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_id(directed_ids[i]);
      sender_gap();
    end
    // sender pause until the block has drained completely
    wait_drained();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 40) long_holdoff = 1'b1;
      if (i == N_RANDOM - 40) quiet_phase = 1'b1;
      case ($urandom_range(0, 3))
        0: id = {$urandom, $urandom};
        1: id = {32'hffff_ffff, $urandom};
        2: id = {$urandom, 32'h0};
        default: id = 64'hffff_ffff_ffff_ffff - {$urandom_range(0, 64), 32'h0};
      endcase
      send_id(id);
      sender_gap();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern; one long hold-off keeps the block full
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (long_holdoff) begin
        long_holdoff = 1'b0;
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 10);
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      n = $urandom_range(1, 20);
      repeat (n) @(negedge clk);
    end
  end

  // checker and watchdog, sampled at the rising edge
  always @(posedge clk) begin
    component_t c;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_components.size() == 0) begin
          $error("unexpected output transaction value=%0d", component_value);
          fail_count++;
        end else begin
          c = expected_components.pop_front();
          if (component_value !== c.value) begin
            $error("component_value expected %0d got %0d", c.value, component_value);
            fail_count++;
          end
          if (is_detail !== c.detail) begin
            $error("is_detail expected %0b got %0b", c.detail, is_detail);
            fail_count++;
          end
          if (component_index !== c.index) begin
            $error("component_index expected %0d got %0d", c.index, component_index);
            fail_count++;
          end
          if (last !== c.last) begin
            $error("last expected %0b got %0b", c.last, last);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: a run with no transaction for too long ends at once
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (expected_components.size() != 0 && idle_cycles < IDLE_LIMIT) @(posedge clk);
    repeat (800) @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
    end else if (fail_count == 0 && expected_components.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/smuv_pkg.sv
design/smuv_datapath.sv
design/smuv_ctrl.sv
design/splitmix_unit_vector_init.sv
design/smuv_checker.sv
sim/splitmix_unit_vector_init_tb.sv
